// ----- sv/cartridge_bus_address_mapper_defines.svh -----
// Assertion helpers for the checker file.
`ifndef CARTRIDGE_BUS_ADDRESS_MAPPER_DEFINES_SVH
`define CARTRIDGE_BUS_ADDRESS_MAPPER_DEFINES_SVH

// Clocked check, quiet while reset is high.
`define CBAM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset.
`define CBAM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/cbam_pkg.sv -----
`default_nettype none

package cbam_pkg;

   localparam int unsigned SRAM_DEPTH_DEFAULT = 524288;

   localparam int unsigned ROM_DIVIDEND_W = 22;
   localparam int unsigned ROM_OFFSET_W   = 23;
   localparam int unsigned ROM_SIZE_W     = 24;
   localparam int unsigned SRAM_OFFSET_W  = 19;

   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_MAX   = 24'h800000;
   localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RESET = 24'h100000;

   // SRAM size: 2^code KB, code 0 disables it, codes above the clamp give the largest size
   localparam logic [3:0] SRAM_CODE_CLAMP = 4'd9;
   localparam logic [4:0] SRAM_LOG_BASE   = 5'd10;
   localparam logic [4:0] SRAM_LOG_MAX    = 5'd19;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_SIZE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRAM_CODE = 2'd2;

   // layouts
   localparam logic [1:0] MAP_LOROM   = 2'd0;
   localparam logic [1:0] MAP_HIROM   = 2'd1;
   localparam logic [1:0] MAP_EXHIROM = 2'd2;

   // access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // result targets
   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_ROM  = 2'd1;
   localparam logic [1:0] TGT_SRAM = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [7:0]  bank;
      logic [15:0] address;
      logic [7:0]  write_data;
   } cbam_req_type;

   typedef struct packed {
      logic [1:0]               target;
      logic [ROM_OFFSET_W-1:0]  rom_offset;
      logic [SRAM_OFFSET_W-1:0] sram_offset;
      logic [7:0]               read_data;
   } cbam_rsp_type;

endpackage

`default_nettype wire

// ----- sv/cartridge_bus_address_mapper.sv -----
// Channel  Ports                             Moves
// -------  --------------------------------  ---------------------------------
// request  req_valid / req_ready / req_data  one bus access (op, bank, addr)
// response rsp_valid / rsp_ready / rsp_data  target, ROM/SRAM offset, SRAM byte
// config   csr_we / csr_index / csr_wdata    map mode, ROM size, SRAM size code
//
// A ROM request waits in ST_DIV on a bit-serial remainder unit that takes one
// of 22 dividend bits per cycle; SRAM accesses pass ST_READ or ST_WRITE and
// others go straight to ST_DONE. req_ready rises in the cycle rsp_valid rises.
// After reset the SRAM is cleared one byte per cycle and no request is taken;
// config writes are taken while reset is low. A waiting response does not
// block the next request, which waits in ST_DONE for a free output register.
`default_nettype none

module cartridge_bus_address_mapper import cbam_pkg::*; #(
   parameter int unsigned SRAM_DEPTH = SRAM_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cbam_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cbam_rsp_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned SRAM_AW     = $clog2(SRAM_DEPTH);
   localparam logic [4:0]  SRAM_AW_LOG = 5'(SRAM_AW);
   localparam int unsigned SPAN_W      = SRAM_OFFSET_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [1:0]            map_mode_ff;
   logic [ROM_SIZE_W-1:0] rom_size_ff;
   logic [3:0]            sram_code_ff;

   // request held while it is worked on
   logic                     op_ff;
   logic [1:0]               tgt_ff;
   logic [SRAM_OFFSET_W-1:0] sram_off_ff;
   logic [7:0]               wdata_ff;
   logic [SRAM_AW-1:0]       clr_addr_ff;

   logic         rsp_valid_ff;
   cbam_rsp_type rsp_data_ff;
   cbam_rsp_type rsp_data_in;

   // SRAM
   logic [7:0]         save_ram [SRAM_DEPTH];
   logic [7:0]         mem_rdata_ff;
   logic [SRAM_AW-1:0] mem_addr;
   logic [7:0]         mem_wdata;
   logic               mem_we;

   // decode
   logic                      accept;
   logic                      is_ex, is_hi, sram_on;
   logic                      lo_sram_bank, hi_rom_bank;
   logic [7:0]                b;
   logic [15:0]               a;
   logic [7:0]                wr_idx, rd_idx;
   logic [4:0]                sram_log;
   logic [SPAN_W-1:0]         sram_mask;
   logic [SPAN_W-1:0]         sram_span;
   logic [1:0]                dec_tgt;
   logic [ROM_DIVIDEND_W-1:0] dec_dividend;
   logic [SRAM_OFFSET_W-1:0]  dec_sram_off;
   logic [ROM_SIZE_W-1:0]     rom_modulus;

   logic                    div_done;
   logic [ROM_OFFSET_W-1:0] div_rem;

   assign accept = req_valid && req_ready;

   always_comb begin
      if (rom_size_ff == '0 || rom_size_ff > ROM_SIZE_MAX) begin
         rom_modulus = ROM_SIZE_MAX;
      end else begin
         rom_modulus = rom_size_ff;
      end

      if (sram_code_ff > SRAM_CODE_CLAMP) begin
         sram_log = SRAM_LOG_MAX;
      end else begin
         sram_log = 5'(sram_code_ff) + SRAM_LOG_BASE;
      end
      if (sram_log > SRAM_AW_LOG) begin
         sram_log = SRAM_AW_LOG;
      end
      sram_mask = (SPAN_W'(1) << sram_log) - SPAN_W'(1);
      sram_on   = (sram_code_ff != '0);
   end

   always_comb begin
      b     = req_data.bank;
      a     = req_data.address;
      is_ex = (map_mode_ff == MAP_EXHIROM);
      is_hi = (map_mode_ff == MAP_HIROM);

      lo_sram_bank = (b >= 8'h70 && b <= 8'h7D) || b >= 8'hF0;
      hi_rom_bank  = (b >= 8'h40 && b <= 8'h7D) || b >= 8'hC0;

      // writes clamp banks below 0x20 to row 0, reads let the index wrap
      if (b >= 8'hA0) begin
         wr_idx = b - 8'hA0;
      end else if (b >= 8'h20) begin
         wr_idx = b - 8'h20;
      end else begin
         wr_idx = '0;
      end
      rd_idx = (b >= 8'hA0) ? b - 8'hA0 : b - 8'h20;

      dec_tgt      = TGT_NONE;
      dec_dividend = '0;
      sram_span    = '0;

      if (req_data.operation == OP_WRITE) begin
         if (is_hi || is_ex) begin
            sram_span = {wr_idx[6:0], a[12:0]};
            if (sram_on && a[15:13] == 3'b011 && (sram_span & ~sram_mask) == '0) begin
               dec_tgt = TGT_SRAM;
            end
         end else begin
            // full 16-bit address lands on the bank base, upper half too
            sram_span = {1'b0, b[3:0], 15'b0} + {4'b0, a};
            if (sram_on && lo_sram_bank && (sram_span & ~sram_mask) == '0) begin
               dec_tgt = TGT_SRAM;
            end
         end
      end else if (is_ex) begin
         if (hi_rom_bank) begin
            dec_tgt      = TGT_ROM;
            dec_dividend = {b[5:0], a};
         end else if (a[15]) begin
            dec_tgt      = TGT_ROM;
            dec_dividend = {1'b1, b[5:0], a[14:0]};
         end else if (sram_on && a[14:13] == 2'b11) begin
            dec_tgt   = TGT_SRAM;
            sram_span = {2'b0, b[4:0], a[12:0]};
         end
      end else if (is_hi) begin
         if (hi_rom_bank || a[15]) begin
            dec_tgt      = TGT_ROM;
            dec_dividend = {b[5:0], a};
         end else if (sram_on && a[14:13] == 2'b11) begin
            dec_tgt   = TGT_SRAM;
            sram_span = {1'b0, rd_idx[5:0], a[12:0]};
         end
      end else begin
         if (a[15]) begin
            dec_tgt      = TGT_ROM;
            dec_dividend = {b[6:0], a[14:0]};
         end else if (sram_on && lo_sram_bank) begin
            dec_tgt   = TGT_SRAM;
            sram_span = {1'b0, b[3:0], a[14:0]};
         end
      end

      dec_sram_off = SRAM_OFFSET_W'(sram_span & sram_mask);
   end

   cbam_rom_mod u_rom_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && dec_tgt == TGT_ROM),
      .dividend  (dec_dividend),
      .modulus   (rom_modulus),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      rsp_data_in.target      = tgt_ff;
      rsp_data_in.rom_offset  = (tgt_ff == TGT_ROM) ? div_rem : '0;
      rsp_data_in.sram_offset = (tgt_ff == TGT_SRAM) ? sram_off_ff : '0;
      rsp_data_in.read_data   = (tgt_ff == TGT_SRAM && op_ff == OP_READ) ? mem_rdata_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff  <= MAP_LOROM;
         rom_size_ff  <= ROM_SIZE_RESET;
         sram_code_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_MODE:  map_mode_ff  <= csr_wdata[1:0];
            CSR_ROM_SIZE:  rom_size_ff  <= csr_wdata[ROM_SIZE_W-1:0];
            CSR_SRAM_CODE: sram_code_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise a finished response once the output register is free
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == SRAM_AW'(SRAM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (dec_tgt == TGT_ROM) begin
                     state_ff <= ST_DIV;
                  end else if (dec_tgt == TGT_SRAM && req_data.operation == OP_WRITE) begin
                     state_ff <= ST_WRITE;
                  end else if (dec_tgt == TGT_SRAM) begin
                     state_ff <= ST_READ;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_READ:  state_ff <= ST_DONE;
            ST_WRITE: state_ff <= ST_DONE;
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_data.operation;
         tgt_ff      <= dec_tgt;
         sram_off_ff <= dec_sram_off;
         wdata_ff    <= req_data.write_data;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      mem_addr  = (state_ff == ST_CLEAR) ? clr_addr_ff : sram_off_ff[SRAM_AW-1:0];
      mem_wdata = (state_ff == ST_CLEAR) ? 8'h00 : wdata_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         save_ram[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= save_ram[mem_addr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/cbam_rom_mod.sv -----
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle.
module cbam_rom_mod import cbam_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ROM_DIVIDEND_W-1:0] dividend,
   input  logic [ROM_SIZE_W-1:0]     modulus,
   output logic                      done,
   output logic [ROM_OFFSET_W-1:0]   remainder
);

   localparam int unsigned CNT_W = $clog2(ROM_DIVIDEND_W);

   logic [ROM_DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [ROM_OFFSET_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [ROM_SIZE_W-1:0]     trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[ROM_DIVIDEND_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CNT_W'(ROM_DIVIDEND_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[ROM_DIVIDEND_W-2:0], 1'b0};
         // the partial remainder stays below the modulus, so it fits
         if (trial >= modulus) begin
            rem_in = ROM_OFFSET_W'(trial - modulus);
         end else begin
            rem_in = trial[ROM_OFFSET_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- sv/cbam_checker.sv -----
`default_nettype none
`include "cartridge_bus_address_mapper_defines.svh"

module cbam_checker import cbam_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire cbam_rsp_type rsp_data
);

   `CBAM_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !req_ready, "busy right after reset")

   `CBAM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   `CBAM_ASSERT(a_none_zero, rsp_valid && rsp_data.target == TGT_NONE |-> rsp_data.rom_offset == '0 && rsp_data.sram_offset == '0 && rsp_data.read_data == '0, "open bus response not zero")

   `CBAM_ASSERT(a_rom_clean, rsp_valid && rsp_data.target == TGT_ROM |-> rsp_data.sram_offset == '0 && rsp_data.read_data == '0, "ROM response carries SRAM fields")

   `CBAM_ASSERT(a_sram_clean, rsp_valid && rsp_data.target == TGT_SRAM |-> rsp_data.rom_offset == '0, "SRAM response carries a ROM offset")

endmodule

bind cartridge_bus_address_mapper cbam_checker u_cbam_checker (.*);

`default_nettype wire
